/* hw/rtl/hrd_pkg.sv */
// Shared types and constants for the HEVC RTP depacketizer.
package hrd_pkg;

  // Input item as seen on the push side
  typedef struct packed {
    logic        op;
    logic [7:0]  payload_byte;
    logic        packet_first;
    logic        packet_last;
    logic [15:0] seq_num;
  } in_t;

  // Result item as seen on the pop side
  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_nal;
    logic       end_of_run;
    logic       missed_packets;
    logic       dropped_fragments;
    logic [2:0] status;
  } out_t;

  // One queued entry: the whole run of results caused by one item.
  // Order of results: start code (3 bytes), data byte, notice.
  typedef struct packed {
    logic       sc;
    logic       sc_eon;
    logic       dat_v;
    logic [7:0] dat;
    logic       dat_eon;
    logic       mem;
    logic       ntc_v;
    logic [2:0] ntc;
    logic       missed;
    logic       dropped;
  } entry_t;

  // Item operations
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FORBID = 3'd1;
  localparam logic [2:0] ST_TRUNC  = 3'd2;
  localparam logic [2:0] ST_OVFL   = 3'd3;
  localparam logic [2:0] ST_BUSY   = 3'd4;
  localparam logic [2:0] ST_MAX    = 3'd4;

  // Packet kinds
  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_AGG    = 2'd1;
  localparam logic [1:0] KIND_FRAG   = 2'd2;

  // Aggregation parse phases
  localparam logic [1:0] PH_LEN_HI = 2'd0;
  localparam logic [1:0] PH_LEN_LO = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  // NAL unit types
  localparam logic [5:0] NAL_AGG = 6'd48;
  localparam logic [5:0] NAL_FU  = 6'd49;

  // Result queue
  localparam int QDEPTH = 8;
  localparam int QAW    = 3;
  localparam int QCW    = 4;

endpackage

/* hw/rtl/hrd_front.sv */
// Front part: parses payload bytes, keeps fragment store, builds result entries.
module hrd_front #(
  parameter int FRAG_BUF_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hrd_pkg::in_t               item,
  input  logic                       take,
  input  logic [hrd_pkg::QCW-1:0]    q_count,
  output logic                       full,
  output logic                       push,
  output hrd_pkg::entry_t            push_entry
);

  localparam int AW = $clog2(FRAG_BUF_BYTES);
  localparam int CW = $clog2(FRAG_BUF_BYTES + 1);
  localparam int PW = $clog2(FRAG_BUF_BYTES + 6);

  // Parser state
  logic [15:0]   last_seq, last_seq_next;
  logic [1:0]    byte_index, byte_index_next;
  logic [1:0]    packet_kind, packet_kind_next;
  logic          discarding, discarding_next;
  logic          header_first, header_first_next;
  logic [7:0]    header_second, header_second_next;
  logic [1:0]    agg_phase, agg_phase_next;
  logic [15:0]   agg_remaining, agg_remaining_next;
  logic [5:0]    fu_type, fu_type_next;
  logic          fu_end_seen, fu_end_seen_next;
  logic          frag_open, frag_open_next;
  logic [CW-1:0] frag_count, frag_count_next;
  logic [PW-1:0] drain_pos, drain_pos_next;
  logic          drain_pending, drain_pending_next;
  logic          missed_pend, missed_pend_next;
  logic          dropped_pend, dropped_pend_next;

  // Second stage
  logic            bvalid;
  hrd_pkg::entry_t bent;
  logic [7:0]      rdata;

  // Fragment store
  logic [7:0]    mem [FRAG_BUF_BYTES];
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  hrd_pkg::entry_t ent;
  logic [1:0]      idx;
  logic            disc;
  logic [5:0]      ntype;
  logic [1:0]      kind;
  logic [15:0]     rem;
  logic [PW-1:0]   total;

  // Hold off input when the queue could not take the entry in flight
  assign full = ({1'b0, q_count} + {{hrd_pkg::QCW{1'b0}}, bvalid})
                >= (hrd_pkg::QCW + 1)'(hrd_pkg::QDEPTH);

  // Classify the item and compute next state and the result entry
  always_comb begin
    last_seq_next      = last_seq;
    byte_index_next    = byte_index;
    packet_kind_next   = packet_kind;
    discarding_next    = discarding;
    header_first_next  = header_first;
    header_second_next = header_second;
    agg_phase_next     = agg_phase;
    agg_remaining_next = agg_remaining;
    fu_type_next       = fu_type;
    fu_end_seen_next   = fu_end_seen;
    frag_open_next     = frag_open;
    frag_count_next    = frag_count;
    drain_pos_next     = drain_pos;
    drain_pending_next = drain_pending;
    missed_pend_next   = missed_pend;
    dropped_pend_next  = dropped_pend;
    ent   = '0;
    we    = 1'b0;
    waddr = frag_count[AW-1:0];
    raddr = AW'(drain_pos - PW'(5));
    idx   = 2'd0;
    disc  = discarding;
    ntype = item.payload_byte[6:1];
    kind  = hrd_pkg::KIND_SINGLE;
    rem   = agg_remaining;
    total = PW'(frag_count) + PW'(5);
    if (take) begin
      if (item.op == hrd_pkg::OP_DRAIN) begin
        // Emit one byte of the reassembled unit
        if (drain_pending) begin
          ent.dat_v = 1'b1;
          if (drain_pos < PW'(2)) begin
            ent.dat = 8'h00;
          end else if (drain_pos == PW'(2)) begin
            ent.dat = 8'h01;
          end else if (drain_pos == PW'(3)) begin
            ent.dat = {1'b0, fu_type, header_first};
          end else if (drain_pos == PW'(4)) begin
            ent.dat = header_second;
          end else begin
            ent.mem = 1'b1;
          end
          ent.dat_eon = (drain_pos + PW'(1)) >= total;
          if (ent.dat_eon) begin
            drain_pending_next = 1'b0;
            drain_pos_next     = '0;
            frag_count_next    = '0;
            frag_open_next     = 1'b0;
          end else begin
            drain_pos_next = drain_pos + PW'(1);
          end
        end
      end else if (item.packet_first || byte_index != 2'd0) begin
        idx = item.packet_first ? 2'd0 : byte_index;
        // Track sequence numbers on the packet's first byte
        if (item.packet_first) begin
          disc           = 1'b0;
          agg_phase_next = hrd_pkg::PH_LEN_HI;
          if (!drain_pending) begin
            if (item.seq_num < last_seq) begin
              disc = 1'b1;
            end else begin
              if ({1'b0, item.seq_num} > ({1'b0, last_seq} + 17'd1)) begin
                missed_pend_next = 1'b1;
              end
              last_seq_next = item.seq_num;
            end
          end
        end
        if (drain_pending) begin
          ent.ntc_v = 1'b1;
          ent.ntc   = hrd_pkg::ST_BUSY;
          disc      = 1'b1;
        end else if (!disc) begin
          if (idx == 2'd0) begin
            // Payload header byte
            header_first_next = item.payload_byte[0];
            if (item.payload_byte[7]) begin
              ent.ntc_v = 1'b1;
              ent.ntc   = hrd_pkg::ST_FORBID;
              disc      = 1'b1;
            end else begin
              if (ntype == hrd_pkg::NAL_AGG) begin
                kind = hrd_pkg::KIND_AGG;
              end else if (ntype == hrd_pkg::NAL_FU) begin
                kind = hrd_pkg::KIND_FRAG;
              end else begin
                kind = hrd_pkg::KIND_SINGLE;
              end
              packet_kind_next = kind;
              if (kind != hrd_pkg::KIND_FRAG) begin
                if (frag_open) begin
                  frag_open_next    = 1'b0;
                  frag_count_next   = '0;
                  dropped_pend_next = 1'b1;
                end
                fu_end_seen_next = 1'b0;
              end
              if (kind == hrd_pkg::KIND_SINGLE) begin
                ent.sc      = 1'b1;
                ent.dat_v   = 1'b1;
                ent.dat     = item.payload_byte;
                ent.dat_eon = item.packet_last;
              end
            end
          end else if (packet_kind == hrd_pkg::KIND_SINGLE) begin
            ent.dat_v   = 1'b1;
            ent.dat     = item.payload_byte;
            ent.dat_eon = item.packet_last;
          end else if (packet_kind == hrd_pkg::KIND_AGG) begin
            // Aggregation: length high, length low, unit bytes
            if (idx[1]) begin
              case (agg_phase)
                hrd_pkg::PH_LEN_HI: begin
                  agg_remaining_next = {item.payload_byte, 8'h00};
                  agg_phase_next     = hrd_pkg::PH_LEN_LO;
                end
                hrd_pkg::PH_LEN_LO: begin
                  rem                = {agg_remaining[15:8], item.payload_byte};
                  agg_remaining_next = rem;
                  ent.sc             = 1'b1;
                  ent.sc_eon         = (rem == 16'd0);
                  agg_phase_next     = (rem != 16'd0) ? hrd_pkg::PH_DATA
                                                      : hrd_pkg::PH_LEN_HI;
                end
                default: begin
                  rem = agg_remaining - {15'd0, (agg_remaining != 16'd0)};
                  agg_remaining_next = rem;
                  ent.dat_v          = 1'b1;
                  ent.dat            = item.payload_byte;
                  ent.dat_eon        = (rem == 16'd0);
                  if (rem == 16'd0) begin
                    agg_phase_next = hrd_pkg::PH_LEN_HI;
                  end
                end
              endcase
            end
          end else begin
            // Fragmentation unit
            if (idx == 2'd1) begin
              header_second_next = item.payload_byte;
            end else if (idx == 2'd2) begin
              if (item.payload_byte[7] && frag_open) begin
                frag_count_next   = '0;
                dropped_pend_next = 1'b1;
              end
              frag_open_next   = 1'b1;
              fu_end_seen_next = item.payload_byte[6];
              fu_type_next     = item.payload_byte[5:0];
            end else if (frag_count >= CW'(FRAG_BUF_BYTES)) begin
              frag_open_next    = 1'b0;
              frag_count_next   = '0;
              fu_end_seen_next  = 1'b0;
              dropped_pend_next = 1'b1;
              ent.ntc_v         = 1'b1;
              ent.ntc           = hrd_pkg::ST_OVFL;
              disc              = 1'b1;
            end else begin
              we              = 1'b1;
              frag_count_next = frag_count + CW'(1);
            end
          end
          // Close the packet
          if (item.packet_last && !disc) begin
            if (packet_kind_next == hrd_pkg::KIND_AGG &&
                (!idx[1] || agg_phase_next != hrd_pkg::PH_LEN_HI)) begin
              ent.ntc_v = 1'b1;
              ent.ntc   = hrd_pkg::ST_TRUNC;
            end
            if (packet_kind_next == hrd_pkg::KIND_FRAG && idx[1] && fu_end_seen_next) begin
              fu_end_seen_next   = 1'b0;
              drain_pending_next = 1'b1;
              drain_pos_next     = '0;
            end
          end
        end
        if (item.packet_last) begin
          byte_index_next = 2'd0;
          disc            = 1'b0;
        end else begin
          byte_index_next = (idx == 2'd3) ? 2'd3 : idx + 2'd1;
        end
        discarding_next = disc;
      end
      // Attach pending event flags to the first result of this item
      if (ent.sc || ent.dat_v || ent.ntc_v) begin
        ent.missed        = missed_pend_next;
        ent.dropped       = dropped_pend_next;
        missed_pend_next  = 1'b0;
        dropped_pend_next = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq      <= '0;
      byte_index    <= '0;
      packet_kind   <= hrd_pkg::KIND_SINGLE;
      discarding    <= 1'b0;
      header_first  <= 1'b0;
      header_second <= '0;
      agg_phase     <= hrd_pkg::PH_LEN_HI;
      agg_remaining <= '0;
      fu_type       <= '0;
      fu_end_seen   <= 1'b0;
      frag_open     <= 1'b0;
      frag_count    <= '0;
      drain_pos     <= '0;
      drain_pending <= 1'b0;
      missed_pend   <= 1'b0;
      dropped_pend  <= 1'b0;
      bvalid        <= 1'b0;
    end else begin
      last_seq      <= last_seq_next;
      byte_index    <= byte_index_next;
      packet_kind   <= packet_kind_next;
      discarding    <= discarding_next;
      header_first  <= header_first_next;
      header_second <= header_second_next;
      agg_phase     <= agg_phase_next;
      agg_remaining <= agg_remaining_next;
      fu_type       <= fu_type_next;
      fu_end_seen   <= fu_end_seen_next;
      frag_open     <= frag_open_next;
      frag_count    <= frag_count_next;
      drain_pos     <= drain_pos_next;
      drain_pending <= drain_pending_next;
      missed_pend   <= missed_pend_next;
      dropped_pend  <= dropped_pend_next;
      bvalid        <= ent.sc || ent.dat_v || ent.ntc_v;
    end
  end

  // Register the entry while the store read completes
  always_ff @(posedge clk) begin
    bent <= ent;
  end

  // Write fragment bytes, read drain bytes
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= item.payload_byte;
    end
    rdata <= mem[raddr];
  end

  // Merge read data into the entry
  always_comb begin
    push       = bvalid;
    push_entry = bent;
    if (bent.mem) begin
      push_entry.dat = rdata;
    end
  end

endmodule

/* hw/rtl/hrd_queue.sv */
// Short queue of result entries between front and back parts.
module hrd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  hrd_pkg::entry_t         push_entry,
  input  logic                    pop,
  output hrd_pkg::entry_t         head,
  output logic [hrd_pkg::QCW-1:0] count,
  output logic                    empty
);

  hrd_pkg::entry_t             slots [hrd_pkg::QDEPTH];
  logic [hrd_pkg::QAW-1:0]     wptr;
  logic [hrd_pkg::QAW-1:0]     rptr;
  logic                        do_pop;

  assign empty  = (count == '0);
  assign head   = slots[rptr];
  assign do_pop = pop && !empty;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + hrd_pkg::QAW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + hrd_pkg::QAW'(1);
      end
      count <= count + hrd_pkg::QCW'(push) - hrd_pkg::QCW'(do_pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

endmodule

/* hw/rtl/hrd_back.sv */
// Back part: expands each queued entry into its result items.
module hrd_back (
  input  logic            clk,
  input  logic            rst,
  input  hrd_pkg::entry_t head,
  input  logic            q_empty,
  input  logic            pop,
  output logic            q_pop,
  output hrd_pkg::out_t   result
);

  logic [2:0] phase;
  logic [2:0] nres;
  logic [2:0] j;

  assign nres = (head.sc ? 3'd3 : 3'd0) + {2'd0, head.dat_v} + {2'd0, head.ntc_v};
  assign j    = phase - (head.sc ? 3'd3 : 3'd0);

  // Select the result for the current position in the entry
  always_comb begin
    result                   = '0;
    result.end_of_run        = (phase == nres - 3'd1);
    result.missed_packets    = (phase == 3'd0) && head.missed;
    result.dropped_fragments = (phase == 3'd0) && head.dropped;
    result.status            = hrd_pkg::ST_OK;
    if (head.sc && phase < 3'd3) begin
      result.out_byte   = (phase == 3'd2) ? 8'h01 : 8'h00;
      result.end_of_nal = (phase == 3'd2) && head.sc_eon;
    end else if (head.dat_v && j == 3'd0) begin
      result.out_byte   = head.dat;
      result.end_of_nal = head.dat_eon;
    end else begin
      result.status = head.ntc;
    end
  end

  assign q_pop = pop && !q_empty && result.end_of_run;

  // Advance through the entry on each pop
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (pop && !q_empty) begin
      phase <= result.end_of_run ? 3'd0 : phase + 3'd1;
    end
  end

endmodule

/* hw/rtl/hevc_rtp_depacketizer.sv */
// Top level of the HEVC RTP depacketizer.
//
// Input channel: push/full with one item on 'item'. A payload byte (op 0)
// carries packet_first/packet_last marks and the RTP sequence number; a
// drain tick (op 1) emits one byte of a reassembled fragmented unit.
// Result channel: empty/pop; 'result' shows the oldest result while empty
// is low. Each item yields zero to four results (start code, data byte,
// status notice); end_of_run marks the last one of an item.
// Throughput: one item per cycle while full is low. The front parser works out
// an item's entry, a second stage registers it together with the fragment store
// read, and the queue then stores it, so an item's first result reaches the ports
// from its queue slot, where it can be popped.
// The back part emits one result per cycle while pop is high, so items yielding several
// results drain slower than they arrive; an 8-entry queue absorbs bursts and
// full rises once it and the stage in flight would be used up.
// Reset (synchronous) clears all parser state and the queue; the fragment
// store is not cleared and needs no sweep. When the receiver stalls, results
// wait in the queue and input is held off by full.
module hevc_rtp_depacketizer #(
  parameter int FRAG_BUF_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  hrd_pkg::in_t  item,
  input  logic          push,
  output logic          full,
  output hrd_pkg::out_t result,
  output logic          empty,
  input  logic          pop
);

  logic                    take;
  logic                    q_push;
  hrd_pkg::entry_t         q_entry;
  hrd_pkg::entry_t         q_head;
  logic [hrd_pkg::QCW-1:0] q_count;
  logic                    q_pop;

  assign take = push && !full;

  hrd_front #(
    .FRAG_BUF_BYTES(FRAG_BUF_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .take       (take),
    .q_count    (q_count),
    .full       (full),
    .push       (q_push),
    .push_entry (q_entry)
  );

  hrd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .count      (q_count),
    .empty      (empty)
  );

  hrd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_empty (empty),
    .pop     (pop),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

/* hw/rtl/hevc_rtp_depacketizer_chk.sv */
// Port checker for the HEVC RTP depacketizer, bound to the top level.
module hrd_chk (
  input logic          clk,
  input logic          rst,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input hrd_pkg::out_t result
);

  // Come out of reset with nothing queued and input open
  a_reset: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not empty or full after reset");

  // Status stays within the defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.status <= hrd_pkg::ST_MAX)
    else $error("undefined status code");

  // Notices carry no stream byte
  a_notice: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != hrd_pkg::ST_OK) |->
      (result.out_byte == 8'h00 && !result.end_of_nal))
    else $error("notice carries stream data");

  // Hold a waiting result until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

endmodule

bind hevc_rtp_depacketizer hrd_chk u_chk (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

/* tb/hevc_rtp_depacketizer_test.sv */
// Self-checking testbench for the HEVC RTP depacketizer, with its own stream predictor.
`timescale 1ns / 1ps

module hevc_rtp_depacketizer_test;

  localparam int STORE_BYTES = 4096;
  localparam int CYCLE_LIMIT = 50000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  hrd_pkg::in_t  item = '0;
  logic          push = 1'b0;
  logic          full;
  hrd_pkg::out_t result;
  logic          empty;
  logic          pop = 1'b0;

  hevc_rtp_depacketizer dut (
    .clk(clk), .rst(rst), .item(item), .push(push), .full(full),
    .result(result), .empty(empty), .pop(pop)
  );

  always #6 clk = ~clk;

  hrd_pkg::in_t  pending_items[$];
  hrd_pkg::out_t stream_due[$];
  int   send_idle = 0;
  int   recv_idle = 0;
  int   hold_req = 0;
  int   hold_left = 0;
  int   mismatches = 0;
  int   items_in = 0;
  int   results_out = 0;
  int   cycles = 0;
  logic [15:0] gen_seq;

  // Predictor state
  int unsigned p_last_seq, p_index, p_kind, p_skip;
  int unsigned p_hdr1, p_hdr2, p_agg_ph, p_agg_left;
  int unsigned p_fu_type, p_fu_end, p_set_open;
  logic [7:0]  p_store[STORE_BYTES];
  int unsigned p_count, p_drain_pos, p_draining, p_missed, p_dropped;
  hrd_pkg::out_t p_run[$];

  // Append one result to the run of the current item; flags ride on it
  task automatic emit(input int unsigned b, input bit eon, input logic [2:0] st);
    hrd_pkg::out_t r;
    r.out_byte = b[7:0];
    r.end_of_nal = eon;
    r.end_of_run = 1'b0;
    r.missed_packets = p_missed[0];
    r.dropped_fragments = p_dropped[0];
    r.status = st;
    p_missed = 0;
    p_dropped = 0;
    p_run = {p_run, r};
  endtask

  task automatic drop_set();
    p_set_open = 0;
    p_count = 0;
    p_fu_end = 0;
    p_dropped = 1;
  endtask

  // Work out the results of one accepted item and queue them
  task automatic depacketize_item(input hrd_pkg::in_t it);
    int unsigned b, idx, t, pos, v;
    bit eon;
    p_run.delete();
    b = it.payload_byte;
    if (it.op == hrd_pkg::OP_DRAIN) begin
      if (p_draining != 0) begin
        pos = p_drain_pos;
        if (pos < 2) v = 0;
        else if (pos == 2) v = 1;
        else if (pos == 3) v = ((p_fu_type << 1) & 8'h7E) | (p_hdr1 & 1);
        else if (pos == 4) v = p_hdr2;
        else v = p_store[pos - 5];
        eon = (pos + 1 >= p_count + 5);
        emit(v, eon, hrd_pkg::ST_OK);
        if (eon) begin
          p_draining = 0; p_drain_pos = 0; p_count = 0; p_set_open = 0;
        end else begin
          p_drain_pos = pos + 1;
        end
      end
    end else if (it.packet_first || p_index != 0) begin
      idx = it.packet_first ? 0 : p_index;
      if (it.packet_first) begin
        p_skip = 0;
        p_agg_ph = hrd_pkg::PH_LEN_HI;
        if (p_draining == 0) begin
          if (it.seq_num < p_last_seq) begin
            p_skip = 1;
          end else begin
            if (it.seq_num > p_last_seq + 1) p_missed = 1;
            p_last_seq = it.seq_num;
          end
        end
      end
      if (p_draining != 0) begin
        emit(0, 1'b0, hrd_pkg::ST_BUSY);
        p_skip = 1;
      end else if (p_skip == 0) begin
        if (idx == 0) begin
          t = (b >> 1) & 8'h3F;
          p_hdr1 = b;
          if (b & 8'h80) begin
            emit(0, 1'b0, hrd_pkg::ST_FORBID);
            p_skip = 1;
          end else begin
            p_kind = (t == hrd_pkg::NAL_AGG) ? hrd_pkg::KIND_AGG :
                     (t == hrd_pkg::NAL_FU) ? hrd_pkg::KIND_FRAG : hrd_pkg::KIND_SINGLE;
            if (p_kind != hrd_pkg::KIND_FRAG) begin
              if (p_set_open != 0) drop_set();
              p_fu_end = 0;
            end
            if (p_kind == hrd_pkg::KIND_SINGLE) begin
              emit(0, 1'b0, hrd_pkg::ST_OK);
              emit(0, 1'b0, hrd_pkg::ST_OK);
              emit(1, 1'b0, hrd_pkg::ST_OK);
              emit(b, it.packet_last, hrd_pkg::ST_OK);
            end
          end
        end else if (p_kind == hrd_pkg::KIND_SINGLE) begin
          emit(b, it.packet_last, hrd_pkg::ST_OK);
        end else if (p_kind == hrd_pkg::KIND_AGG) begin
          if (idx >= 2) begin
            if (p_agg_ph == hrd_pkg::PH_LEN_HI) begin
              p_agg_left = b << 8;
              p_agg_ph = hrd_pkg::PH_LEN_LO;
            end else if (p_agg_ph == hrd_pkg::PH_LEN_LO) begin
              p_agg_left |= b;
              emit(0, 1'b0, hrd_pkg::ST_OK);
              emit(0, 1'b0, hrd_pkg::ST_OK);
              emit(1, p_agg_left == 0, hrd_pkg::ST_OK);
              p_agg_ph = (p_agg_left != 0) ? hrd_pkg::PH_DATA : hrd_pkg::PH_LEN_HI;
            end else begin
              if (p_agg_left != 0) p_agg_left--;
              emit(b, p_agg_left == 0, hrd_pkg::ST_OK);
              if (p_agg_left == 0) p_agg_ph = hrd_pkg::PH_LEN_HI;
            end
          end
        end else begin
          if (idx == 1) begin
            p_hdr2 = b;
          end else if (idx == 2) begin
            if ((b & 8'h80) && p_set_open != 0) drop_set();
            p_set_open = 1;
            p_fu_end = (b >> 6) & 1;
            p_fu_type = b & 8'h3F;
          end else if (p_count >= STORE_BYTES) begin
            drop_set();
            emit(0, 1'b0, hrd_pkg::ST_OVFL);
            p_skip = 1;
          end else begin
            p_store[p_count] = b[7:0];
            p_count++;
          end
        end
        if (it.packet_last && p_skip == 0) begin
          if (p_kind == hrd_pkg::KIND_AGG && (idx < 2 || p_agg_ph != hrd_pkg::PH_LEN_HI))
            emit(0, 1'b0, hrd_pkg::ST_TRUNC);
          if (p_kind == hrd_pkg::KIND_FRAG && idx >= 2 && p_fu_end != 0) begin
            p_fu_end = 0;
            p_draining = 1;
            p_drain_pos = 0;
          end
        end
      end
      if (it.packet_last) begin
        p_index = 0;
        p_skip = 0;
      end else begin
        p_index = (idx < 16'hFFFF) ? idx + 1 : 16'hFFFF;
      end
    end
    if (p_run.size() > 0) p_run[p_run.size() - 1].end_of_run = 1'b1;
    stream_due = {stream_due, p_run};
  endtask

  // Driver: offer the oldest pending item, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        depacketize_item(item);
        items_in++;
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        push <= 1'b1;
        item <= pending_items[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver hold-off: count down a requested stretch of cycles
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req > 0) begin
      hold_left <= hold_req;
      hold_req = 0;
    end
  end

  // Monitor: compare each popped result with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_out++;
        if (stream_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result);
        end else begin
          if (result !== stream_due[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %p, got %p", results_out, stream_due[0], result);
          end
          void'(stream_due.pop_front());
        end
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("hevc_rtp_depacketizer: mismatch");
      $finish;
    end
  end

  task automatic put_byte(input logic op, input int unsigned b, input bit f, input bit l,
                          input logic [15:0] s);
    hrd_pkg::in_t it;
    it.op = op;
    it.payload_byte = b[7:0];
    it.packet_first = f;
    it.packet_last = l;
    it.seq_num = s;
    pending_items = {pending_items, it};
  endtask

  // Mostly in order; sometimes a gap or a late packet
  function automatic logic [15:0] next_seq();
    int r;
    r = $urandom_range(99);
    if (r < 8) return gen_seq - 16'($urandom_range(5, 1));
    if (r < 18) gen_seq = gen_seq + 16'($urandom_range(6, 2));
    else gen_seq = gen_seq + 16'd1;
    return gen_seq;
  endfunction

  // Send a packet from a byte list
  task automatic put_packet(input int unsigned bytes[$], input logic [15:0] s);
    foreach (bytes[i])
      put_byte(hrd_pkg::OP_DATA, bytes[i], i == 0, i == bytes.size() - 1, s);
  endtask

  function automatic int unsigned nal_hdr(input int unsigned t);
    return ((t & 8'h3F) << 1) | $urandom_range(1);
  endfunction

  task automatic gen_single(input int len);
    int unsigned pk[$];
    int unsigned t;
    do t = $urandom_range(47); while (0);
    pk = {pk, nal_hdr($urandom_range(1) ? t : $urandom_range(63, 50))};
    repeat (len - 1) pk = {pk, $urandom_range(255)};
    put_packet(pk, next_seq());
  endtask

  task automatic gen_agg(input int units, input bit cut);
    int unsigned pk[$];
    int n;
    pk = {pk, nal_hdr(hrd_pkg::NAL_AGG)};
    pk = {pk, $urandom_range(255)};
    repeat (units) begin
      n = $urandom_range(4);
      pk = {pk, 32'(n >> 8)};
      pk = {pk, 32'(n & 8'hFF)};
      repeat (n) pk = {pk, $urandom_range(255)};
    end
    if (cut) repeat ($urandom_range(2, 1)) void'(pk.pop_back());
    if (pk.size() == 0) pk = {pk, nal_hdr(hrd_pkg::NAL_AGG)};
    put_packet(pk, next_seq());
  endtask

  // Fragment set of one or more packets, then enough drain ticks when finish is set
  task automatic gen_fu(input int pkts, input int maxlen, input bit finish);
    int unsigned pk[$];
    int unsigned ty;
    int total;
    total = 0;
    ty = $urandom_range(63);
    for (int p = 0; p < pkts; p++) begin
      pk.delete();
      pk = {pk, nal_hdr(hrd_pkg::NAL_FU)};
      pk = {pk, $urandom_range(255)};
      pk = {pk, 32'(((p == 0) << 7) | ((finish && p == pkts - 1) << 6) | ty)};
      repeat ($urandom_range(maxlen)) begin
        pk = {pk, $urandom_range(255)};
        total++;
      end
      put_packet(pk, next_seq());
    end
    if (finish) repeat (total + 5 + $urandom_range(2))
      put_byte(hrd_pkg::OP_DRAIN, $urandom_range(255), 1'($urandom_range(1)),
               1'($urandom_range(1)), 16'($urandom));
  endtask

  // Noise and broken sequences
  task automatic gen_noise();
    case ($urandom_range(4))
      0: put_byte(1'($urandom_range(1)), $urandom_range(255), 1'($urandom_range(1)),
                  1'($urandom_range(1)), next_seq());
      1: put_byte(hrd_pkg::OP_DATA, $urandom_range(255), 1'b0, 1'($urandom_range(1)),
                  gen_seq);
      2: put_byte(hrd_pkg::OP_DATA, 8'h80 | $urandom_range(127), 1'b1,
                  1'($urandom_range(1)), next_seq());
      3: begin
        put_byte(hrd_pkg::OP_DATA, nal_hdr(1), 1'b1, 1'b0, next_seq());
        put_byte(hrd_pkg::OP_DATA, $urandom_range(255), 1'b0, 1'b0, gen_seq);
      end
      default: begin
        // payload that may arrive while a reassembled unit is still draining
        gen_fu(1, 3, 1'b0);
        gen_fu(1, 3, 1'b1);
        void'(pending_items.pop_back());
        gen_single(2);
        repeat (12) put_byte(hrd_pkg::OP_DRAIN, 0, 1'b0, 1'b0, 16'd0);
      end
    endcase
  endtask

  task automatic gen_random(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 30) gen_single($urandom_range(4, 1));
      else if (r < 50) gen_agg($urandom_range(3, 1), $urandom_range(5) == 0);
      else if (r < 75) gen_fu($urandom_range(3, 1), 4, $urandom_range(5) != 0);
      else gen_noise();
    end
  endtask

  task automatic wait_done();
    while (pending_items.size() > 0 || push) @(posedge clk);
  endtask

  initial begin
    int unsigned pk[$];
    p_last_seq = 0; p_index = 0; p_kind = hrd_pkg::KIND_SINGLE; p_skip = 0;
    p_hdr1 = 0; p_hdr2 = 0; p_agg_ph = hrd_pkg::PH_LEN_HI; p_agg_left = 0;
    p_fu_type = 0; p_fu_end = 0; p_set_open = 0; p_count = 0;
    p_drain_pos = 0; p_draining = 0; p_missed = 0; p_dropped = 0;
    gen_seq = 16'($urandom_range(1000, 10));
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, each packet type and the special cases
    put_byte(hrd_pkg::OP_DRAIN, 0, 1'b0, 1'b0, 16'd0);            // idle drain tick
    put_byte(hrd_pkg::OP_DATA, 8'hFF, 1'b0, 1'b1, gen_seq);       // stray byte
    put_byte(hrd_pkg::OP_DATA, 8'h00, 1'b1, 1'b1, next_seq());    // one-byte single unit
    put_byte(hrd_pkg::OP_DATA, 8'hFF, 1'b1, 1'b1, next_seq());    // forbidden bit
    gen_seq = gen_seq + 16'd4;
    pk = '{nal_hdr(5), 8'hFF, 8'h00};
    put_packet(pk, gen_seq);                                      // after a gap
    put_byte(hrd_pkg::OP_DATA, nal_hdr(3), 1'b1, 1'b1, gen_seq - 16'd2); // late packet
    pk = '{nal_hdr(hrd_pkg::NAL_AGG), 8'h01, 8'h00, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55};
    put_packet(pk, next_seq());                                   // aggregate with an empty unit
    pk = '{nal_hdr(hrd_pkg::NAL_AGG), 8'h01, 8'h00};
    put_packet(pk, next_seq());                                   // truncated aggregate
    pk = '{nal_hdr(hrd_pkg::NAL_FU), 8'h01};
    put_packet(pk, next_seq());                                   // short fragment packet
    gen_fu(2, 3, 1'b0);
    gen_single(2);                                                // unfinished set dropped
    gen_fu(1, 3, 1'b0);
    gen_fu(2, 4, 1'b1);                                           // new start drops the open set
    gen_random(2);
    wait_done();

    // Receiver holds off while the sender keeps pushing
    hold_req = 150;
    gen_random(5);
    wait_done();

    send_idle = 59;
    gen_random(2);
    wait_done();
    send_idle = 0;
    recv_idle = 59;
    gen_random(2);
    wait_done();
    send_idle = 38;
    recv_idle = 38;
    gen_random(2);
    // top sequence number, then one below it is late
    put_byte(hrd_pkg::OP_DATA, nal_hdr(2), 1'b1, 1'b1, 16'hFFFF);
    put_byte(hrd_pkg::OP_DATA, nal_hdr(2), 1'b1, 1'b1, 16'hFFFE);
    wait_done();

    while (stream_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d items and %0d results: single, aggregate, fragment sets, drains,",
             items_in, results_out);
    $display("late, gap, forbidden, truncation and busy cases under back-pressure");
    if (mismatches == 0 && stream_due.size() == 0) begin
      $display("hevc_rtp_depacketizer: match");
    end else begin
      $display("hevc_rtp_depacketizer: mismatch");
    end
    $finish;
  end

endmodule
